// ----- rtl/core/lzbd_pkg.sv -----
// Shared types and constants of the LZ back-reference packet decoder.
`default_nettype none

package lzbd_pkg;

    // Packet header fields of the first byte.
    localparam logic [7:0] LEN_MASK = 8'h3F;
    localparam logic [7:0] TAG_MASK = 8'hC0;

    // Four short packets share one recycled offset byte.
    localparam int unsigned RECYCLE_GROUPS = 4;
    localparam logic [1:0]  RECYCLE_LAST   = 2'(RECYCLE_GROUPS - 1);

    // A long packet's length byte is biased by this amount.
    localparam int unsigned LONG_LEN_BIAS = 3;

    // Offset reaches 1024 and length reaches 258.
    localparam int unsigned OFF_W  = 11;
    localparam int unsigned LEN_W  = 9;
    localparam int unsigned VCNT_W = 4;

    // Parser and copy states.
    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_SHORT_OFF = 5'b00010,
        ST_LONG_OFF  = 5'b00100,
        ST_LONG_LEN  = 5'b01000,
        ST_COPY      = 5'b10000
    } state_t;

    // Where the copy offset comes from.
    typedef enum logic [1:0] {
        OFF_RECYCLE = 2'd0,
        OFF_SHORT   = 2'd1,
        OFF_LONG    = 2'd2
    } off_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     literal_wr;
        logic     hold_first;
        logic     hold_off_low;
        logic     rec_update;
        logic     start_copy;
        off_sel_t off_sel;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic short_start;
        logic rec_last;
        logic copy_done;
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/lzbd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module lzbd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; a read of the address being written returns old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lzbd_ctrl.sv -----
// Packet parser and copy sequencing state machine.
`default_nettype none

module lzbd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_func,
    output logic              in_ready,
    input  lzbd_pkg::status_t status,
    output lzbd_pkg::cmd_t    cmd
);

    import lzbd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   pkt_acc;

    // Requests are taken in every parse state; the copy holds the input off.
    always_comb
    begin
        in_ready       = (state_reg != ST_COPY);
        pkt_acc        = in_valid && in_ready && !in_func;
        cmd            = '0;
        cmd.off_sel    = OFF_SHORT;
        cmd.literal_wr = in_valid && in_ready && in_func;
        state_next     = state_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pkt_acc)
                begin
                    cmd.hold_first = 1'b1;
                    if (status.short_start)
                    begin
                        cmd.rec_update = 1'b1;
                        if (status.rec_last)
                        begin
                            cmd.start_copy = 1'b1;
                            cmd.off_sel    = OFF_RECYCLE;
                            state_next     = ST_COPY;
                        end
                        else
                        begin
                            state_next = ST_SHORT_OFF;
                        end
                    end
                    else
                    begin
                        state_next = ST_LONG_OFF;
                    end
                end
            end
            ST_SHORT_OFF:
            begin
                if (pkt_acc)
                begin
                    cmd.start_copy = 1'b1;
                    cmd.off_sel    = OFF_SHORT;
                    state_next     = ST_COPY;
                end
            end
            ST_LONG_OFF:
            begin
                if (pkt_acc)
                begin
                    cmd.hold_off_low = 1'b1;
                    state_next       = ST_LONG_LEN;
                end
            end
            ST_LONG_LEN:
            begin
                if (pkt_acc)
                begin
                    cmd.start_copy = 1'b1;
                    cmd.off_sel    = OFF_LONG;
                    state_next     = ST_COPY;
                end
            end
            ST_COPY:
            begin
                if (status.copy_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lzbd_dp.sv -----
// Datapath: packet fields, history memory, byte copy engine and output groups.
`default_nettype none

module lzbd_dp #(
    parameter int unsigned HISTORY_DEPTH = 1024,
    parameter int unsigned OUT_LANES     = 8,
    localparam int unsigned TDATA_W = ((OUT_LANES * 8 + lzbd_pkg::VCNT_W + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         in_data,
    input  lzbd_pkg::cmd_t     cmd,
    output lzbd_pkg::status_t  status,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [TDATA_W-1:0] out_data,
    output logic               out_last
);

    import lzbd_pkg::*;

    localparam int unsigned    AW        = $clog2(HISTORY_DEPTH);
    localparam int unsigned    LW        = $clog2(OUT_LANES);
    localparam logic [AW:0]    DEPTH_X   = (AW + 1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0]  LAST_ADDR = AW'(HISTORY_DEPTH - 1);
    localparam logic [LW-1:0]  LAST_LANE = LW'(OUT_LANES - 1);

    // Packet fields and recycle byte.
    logic [7:0]              first_reg, first_next;
    logic [7:0]              offlo_reg, offlo_next;
    logic [7:0]              rb_reg, rb_next;
    logic [1:0]              rc_reg, rc_next;

    // History pointers.
    logic [AW-1:0]           wp_reg, wp_next;
    logic                    wrapped_reg, wrapped_next;
    logic [AW-1:0]           src_reg, src_next;

    // Copy engine.
    logic [LEN_W-1:0]        rd_left_reg, rd_left_next;
    logic                    infl_reg, infl_next;
    logic                    infl_last_reg, infl_last_next;
    logic                    fwd_reg, fwd_next;
    logic [7:0]              fwd_byte_reg, fwd_byte_next;
    logic                    zero_reg, zero_next;
    logic [LW-1:0]           lane_reg, lane_next;
    logic [OUT_LANES-1:0][7:0] asm_reg, asm_next, asm_fill;
    logic                    pend_reg, pend_next;
    logic [VCNT_W-1:0]       pend_vcnt_reg, pend_vcnt_next;
    logic                    pend_last_reg, pend_last_next;

    // Output register.
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_LANES-1:0][7:0] out_byte_reg, out_byte_next;
    logic [VCNT_W-1:0]       out_vcnt_reg, out_vcnt_next;
    logic                    out_last_reg, out_last_next;

    // Combinational helpers.
    logic [7:0]              rb_or;
    logic [OFF_W-1:0]        copy_off;
    logic [LEN_W-1:0]        copy_len;
    logic [AW:0]             src_sum;
    logic [AW-1:0]           start_src;
    logic [7:0]              ram_q;
    logic [7:0]              land_byte;
    logic                    grp_done;
    logic                    out_free;
    logic                    issue;
    logic                    load_grp;
    logic                    load_pend;
    logic [VCNT_W-1:0]       land_vcnt;
    logic                    ram_we;
    logic [7:0]              ram_wdata;

    // History memory.
    lzbd_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (src_reg),
        .rdata (ram_q)
    );

    // Offset and length of the packet that starts a copy.
    always_comb
    begin
        rb_or = rb_reg | ((in_data & TAG_MASK) >> {rc_reg, 1'b0});
        case (cmd.off_sel)
            OFF_RECYCLE:
            begin
                copy_off = OFF_W'(rb_or) + OFF_W'(1);
                copy_len = LEN_W'(in_data & LEN_MASK) + LEN_W'(1);
            end
            OFF_SHORT:
            begin
                copy_off = OFF_W'(in_data) + OFF_W'(1);
                copy_len = LEN_W'(first_reg & LEN_MASK) + LEN_W'(1);
            end
            OFF_LONG:
            begin
                copy_off = (OFF_W'({first_reg & TAG_MASK, 2'b00}) | OFF_W'(offlo_reg))
                           + OFF_W'(1);
                copy_len = LEN_W'(in_data) + LEN_W'(LONG_LEN_BIAS);
            end
            default:
            begin
                copy_off = OFF_W'(1);
                copy_len = LEN_W'(1);
            end
        endcase
        src_sum = {1'b0, wp_reg} + DEPTH_X - (AW + 1)'(copy_off);
        if (src_sum >= DEPTH_X)
        begin
            start_src = AW'(src_sum - DEPTH_X);
        end
        else
        begin
            start_src = AW'(src_sum);
        end
    end

    // Byte landing from the memory, with same-cycle write forwarding.
    always_comb
    begin
        if (fwd_reg)
        begin
            land_byte = fwd_byte_reg;
        end
        else if (zero_reg)
        begin
            land_byte = 8'h00;
        end
        else
        begin
            land_byte = ram_q;
        end
        asm_fill = asm_reg;
        if (infl_reg)
        begin
            asm_fill[lane_reg] = land_byte;
        end
        land_vcnt = VCNT_W'({1'b0, lane_reg} + (LW + 1)'(1));
        grp_done  = infl_reg && ((lane_reg == LAST_LANE) || infl_last_reg);
        out_free  = !out_valid_reg || out_ready;
        issue     = (rd_left_reg != '0) && !pend_reg && !(grp_done && !out_free);
        load_grp  = grp_done && out_free;
        load_pend = pend_reg && out_free;
        ram_we    = infl_reg || cmd.literal_wr;
        ram_wdata = infl_reg ? land_byte : in_data;
    end

    // Next-state logic of the whole datapath.
    always_comb
    begin
        first_next     = first_reg;
        offlo_next     = offlo_reg;
        rb_next        = rb_reg;
        rc_next        = rc_reg;
        wp_next        = wp_reg;
        wrapped_next   = wrapped_reg;
        src_next       = src_reg;
        rd_left_next   = rd_left_reg;
        infl_next      = issue;
        infl_last_next = issue && (rd_left_reg == LEN_W'(1));
        fwd_next       = fwd_reg;
        fwd_byte_next  = fwd_byte_reg;
        zero_next      = zero_reg;
        lane_next      = lane_reg;
        asm_next       = asm_reg;
        pend_next      = pend_reg;
        pend_vcnt_next = pend_vcnt_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_vcnt_next  = out_vcnt_reg;
        out_last_next  = out_last_reg;

        // Packet header bookkeeping.
        if (cmd.hold_first)
        begin
            first_next = in_data;
        end
        if (cmd.hold_off_low)
        begin
            offlo_next = in_data;
        end
        if (cmd.rec_update)
        begin
            rc_next = rc_reg + 2'd1;
            rb_next = (rc_reg == RECYCLE_LAST) ? 8'h00 : rb_or;
        end

        // History write pointer advances on every write.
        if (ram_we)
        begin
            if (wp_reg == LAST_ADDR)
            begin
                wp_next      = '0;
                wrapped_next = 1'b1;
            end
            else
            begin
                wp_next = wp_reg + AW'(1);
            end
        end

        // Copy start and read issue.
        if (cmd.start_copy)
        begin
            src_next     = start_src;
            rd_left_next = copy_len;
        end
        else if (issue)
        begin
            src_next      = (src_reg == LAST_ADDR) ? '0 : src_reg + AW'(1);
            rd_left_next  = rd_left_reg - LEN_W'(1);
            fwd_next      = infl_reg && (src_reg == wp_reg);
            fwd_byte_next = land_byte;
            zero_next     = !wrapped_reg && (src_reg >= wp_reg);
        end

        // Group assembly.
        if (infl_reg)
        begin
            lane_next = grp_done ? '0 : lane_reg + LW'(1);
            asm_next  = asm_fill;
        end
        if (grp_done && !out_free)
        begin
            pend_next      = 1'b1;
            pend_vcnt_next = land_vcnt;
            pend_last_next = infl_last_reg;
        end
        else if (load_pend)
        begin
            pend_next = 1'b0;
        end

        // Output register.
        if (load_grp)
        begin
            out_byte_next = asm_fill;
            out_vcnt_next = land_vcnt;
            out_last_next = infl_last_reg;
            asm_next      = '0;
        end
        else if (load_pend)
        begin
            out_byte_next = asm_reg;
            out_vcnt_next = pend_vcnt_reg;
            out_last_next = pend_last_reg;
            asm_next      = '0;
        end
        if (load_grp || load_pend)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= '0;
            offlo_reg     <= '0;
            rb_reg        <= '0;
            rc_reg        <= '0;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            rd_left_reg   <= '0;
            infl_reg      <= 1'b0;
            infl_last_reg <= 1'b0;
            fwd_reg       <= 1'b0;
            zero_reg      <= 1'b0;
            lane_reg      <= '0;
            asm_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            first_reg     <= first_next;
            offlo_reg     <= offlo_next;
            rb_reg        <= rb_next;
            rc_reg        <= rc_next;
            wp_reg        <= wp_next;
            wrapped_reg   <= wrapped_next;
            rd_left_reg   <= rd_left_next;
            infl_reg      <= infl_next;
            infl_last_reg <= infl_last_next;
            fwd_reg       <= fwd_next;
            zero_reg      <= zero_next;
            lane_reg      <= lane_next;
            asm_reg       <= asm_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        src_reg       <= src_next;
        fwd_byte_reg  <= fwd_byte_next;
        pend_vcnt_reg <= pend_vcnt_next;
        pend_last_reg <= pend_last_next;
        out_byte_reg  <= out_byte_next;
        out_vcnt_reg  <= out_vcnt_next;
        out_last_reg  <= out_last_next;
    end

    // Status and output packing.
    always_comb
    begin
        status.short_start = (in_data & LEN_MASK) != 8'h00;
        status.rec_last    = (rc_reg == RECYCLE_LAST);
        status.copy_done   = (rd_left_reg == '0) && !infl_reg && !pend_reg;
        out_valid          = out_valid_reg;
        out_last           = out_last_reg;
        out_data           = '0;
        for (int i = 0; i < OUT_LANES; i++)
        begin
            out_data[i * 8 +: 8] = out_byte_reg[i];
        end
        out_data[OUT_LANES * 8 +: VCNT_W] = out_vcnt_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/core/lz_backref_packet_decoder.sv -----
// Top level of the LZ back-reference packet decoder.
//
//  Channel | Direction | tdata (low bit up)                    | tuser | tlast
//  --------+-----------+---------------------------------------+-------+-----------
//  s_*     | in        | data_byte[7:0]                        | func  | -
//  m_*     | out       | out_byte0..out_byte(N-1), valid_count | -     | last_group
//
//  Literal requests and header bytes are taken whenever no copy is running.
//  A copy reads the history memory one byte per cycle over its single read port while
//  the output accepts groups, and ends once its last byte has landed in a group.
//  The input is held off for the whole copy; a stalled output pauses the copy.
//  Reset takes effect at once; unwritten history reads as zero without a clearing pass.
`default_nettype none

module lz_backref_packet_decoder #(
    parameter int unsigned HISTORY_DEPTH = 1024,
    parameter int unsigned OUT_LANES     = 8,
    localparam int unsigned TDATA_W = ((OUT_LANES * 8 + lzbd_pkg::VCNT_W + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // data_byte
    input  logic               s_tuser,   // func
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // out_byte0 .. out_byte(OUT_LANES-1), valid_count
    output logic               m_tlast    // last_group
);

    import lzbd_pkg::*;

    localparam int unsigned VC_LO = OUT_LANES * 8;

    cmd_t    cmd;
    status_t status;

    // Packet parser and copy sequencer.
    lzbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_func  (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // History, copy engine and output register.
    lzbd_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .OUT_LANES     (OUT_LANES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

    // Every group but the last of a copy is full.
    a_full_groups: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[VC_LO +: VCNT_W] == VCNT_W'(OUT_LANES))
        else $error("non-final group is not full");

    // Starting a copy closes the input.
    a_copy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_copy |=> !s_tready)
        else $error("input open during copy");

    // The input only opens when no copy work is left.
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> status.copy_done)
        else $error("input open with copy work pending");

endmodule

`default_nettype wire

// ----- test/lzbd_copy_checker.sv -----
// Checker for the LZ back-reference packet decoder: predicts every copy group and compares it.
`default_nettype none

module lzbd_copy_checker #(
    parameter int unsigned TDATA_W = 72
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [7:0]         s_tdata,   // data_byte
    input  wire logic               s_tuser,   // func
    input  wire logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire logic [TDATA_W-1:0] m_tdata,   // out_byte0 .. out_byte7, valid_count
    input  wire logic               m_tlast,   // last_group
    output int                      fail_count,
    output int                      pending,
    output int                      groups_seen
);

    import lzbd_pkg::*;

    localparam int unsigned HIST_DEPTH = 1024;
    localparam int unsigned LANES      = 8;

    // One group of copied bytes as the block should emit it.
    typedef struct packed {
        logic [LANES-1:0][7:0] lanes;
        logic [VCNT_W-1:0]     count;
        logic                  last;
    } copy_group_t;

    // Shadow copy of the decoder's state.
    logic [7:0]  history_mem [HIST_DEPTH];
    int unsigned wr_ptr;
    logic [7:0]  rec_bits;
    logic [1:0]  rec_count;
    state_t      parse_st;
    logic [7:0]  held_hdr;
    logic [7:0]  held_off_lo;

    copy_group_t group_q[$];

    // Append one byte to the shadow history.
    task automatic append_byte(input logic [7:0] b);
        history_mem[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
    endtask

    // Replay a back-reference copy byte by byte and queue the groups it yields.
    task automatic replay_copy(input int unsigned offset, input int unsigned length);
        int unsigned src;
        int unsigned done_n;
        int unsigned lane;
        logic [7:0]  b;
        copy_group_t grp;
        src = (wr_ptr + HIST_DEPTH - (offset % (HIST_DEPTH + 1))) % HIST_DEPTH;
        done_n = 0;
        while (done_n < length)
        begin
            grp = '0;
            for (lane = 0; lane < LANES && done_n < length; lane++)
            begin
                b = history_mem[src];
                append_byte(b);
                src = (src + 1) % HIST_DEPTH;
                grp.lanes[lane] = b;
                grp.count = grp.count + 1'b1;
                done_n++;
            end
            grp.last = (done_n >= length);
            group_q.push_back(grp);
        end
    endtask

    // Advance the shadow parser by one accepted request.
    task automatic predict_request(input logic func, input logic [7:0] b);
        int unsigned off;
        if (func)
        begin
            append_byte(b);
        end
        else
        begin
            case (parse_st)
                ST_IDLE:
                begin
                    held_hdr = b;
                    if ((b & LEN_MASK) != 0)
                    begin
                        rec_bits = rec_bits | ((b & TAG_MASK) >> (2 * rec_count));
                        if (rec_count == RECYCLE_LAST)
                        begin
                            // Fourth short packet: offset comes from the recycled bits.
                            rec_count = '0;
                            off = int'(rec_bits) + 1;
                            rec_bits = '0;
                            parse_st = ST_IDLE;
                            replay_copy(off, int'(b & LEN_MASK) + 1);
                        end
                        else
                        begin
                            rec_count = rec_count + 1'b1;
                            parse_st = ST_SHORT_OFF;
                        end
                    end
                    else
                    begin
                        parse_st = ST_LONG_OFF;
                    end
                end
                ST_SHORT_OFF:
                begin
                    parse_st = ST_IDLE;
                    replay_copy(int'(b) + 1, int'(held_hdr & LEN_MASK) + 1);
                end
                ST_LONG_OFF:
                begin
                    held_off_lo = b;
                    parse_st = ST_LONG_LEN;
                end
                default:
                begin
                    parse_st = ST_IDLE;
                    off = int'({held_hdr[7:6], held_off_lo}) + 1;
                    replay_copy(off, int'(b) + LONG_LEN_BIAS);
                end
            endcase
        end
    endtask

    // Compare one emitted group with the oldest prediction.
    task automatic check_group();
        copy_group_t exp_grp;
        logic [LANES-1:0][7:0] act_lanes;
        logic [VCNT_W-1:0] act_count;
        int unsigned lane;
        act_lanes = m_tdata[LANES*8-1:0];
        act_count = m_tdata[LANES*8 +: VCNT_W];
        groups_seen++;
        if (group_q.size() == 0)
        begin
            fail_count++;
            $display("%0t: unexpected copy group, expected none, got data %h count %0d last %0b",
                     $time, act_lanes, act_count, m_tlast);
        end
        else
        begin
            exp_grp = group_q.pop_front();
            for (lane = 0; lane < LANES; lane++)
            begin
                if (act_lanes[lane] !== exp_grp.lanes[lane])
                begin
                    fail_count++;
                    $display("%0t: group %0d lane %0d expected %02h got %02h",
                             $time, groups_seen, lane, exp_grp.lanes[lane], act_lanes[lane]);
                end
            end
            if (act_count !== exp_grp.count)
            begin
                fail_count++;
                $display("%0t: group %0d valid_count expected %0d got %0d",
                         $time, groups_seen, exp_grp.count, act_count);
            end
            if (m_tlast !== exp_grp.last)
            begin
                fail_count++;
                $display("%0t: group %0d last_group expected %0b got %0b",
                         $time, groups_seen, exp_grp.last, m_tlast);
            end
        end
    endtask

    // Requests are predicted before groups are checked at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
                history_mem[i] = '0;
            wr_ptr      = 0;
            rec_bits    = '0;
            rec_count   = '0;
            parse_st    = ST_IDLE;
            held_hdr    = '0;
            held_off_lo = '0;
            group_q.delete();
            fail_count  = 0;
            groups_seen = 0;
            pending     = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                check_group();
            pending = group_q.size();
        end
    end

endmodule

`default_nettype wire

// ----- test/tb_lz_backref_packet_decoder.sv -----
// Top-level testbench of the LZ back-reference packet decoder: stimulus, stalls and verdict.
`default_nettype none

module tb_lz_backref_packet_decoder;
    import lzbd_pkg::*;

    localparam int unsigned TDW            = ((8 * 8 + VCNT_W + 7) / 8) * 8;
    localparam int          CYCLE_LIMIT    = 1_000_000;
    localparam int          REQUEST_TARGET = 410;
    localparam int          RX_HOLD_CYCLES = 400;
    localparam int          DRAIN_CYCLES   = 20;

    logic           clk;
    logic           rst_n;
    logic           s_tvalid;
    logic           s_tready;
    logic [7:0]     s_tdata;
    logic           s_tuser;
    logic           m_tvalid;
    logic           m_tready;
    logic [TDW-1:0] m_tdata;
    logic           m_tlast;

    int fail_count;
    int pending;
    int groups_seen;

    int   cycles        = 0;
    int   requests_sent = 0;
    int   literals_sent = 0;
    int   tx_idle_pct   = 18;
    int   rx_idle_pct   = 69;
    int   mid_lit_pct   = 0;
    logic rx_hold_go    = 1'b0;
    logic rx_hold_done  = 1'b0;

    // Packet framing as seen by the sender, used to build well-formed packets.
    state_t     hdr_phase = ST_IDLE;
    logic [1:0] short_cnt = '0;

    lz_backref_packet_decoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    lzbd_copy_checker #(
        .TDATA_W (TDW)
    ) chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .pending     (pending),
        .groups_seen (groups_seen)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run timeout.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_lz_backref_packet_decoder failed");
            $finish;
        end
    end

    // Output side: random stalls plus one long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_go && !rx_hold_done)
            begin
                rx_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
            end
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Offer one request, with random idle cycles ahead of it, and wait for its acceptance.
    task automatic send_item(input logic func, input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        requests_sent++;
        if (func)
        begin
            literals_sent++;
        end
        else
        begin
            case (hdr_phase)
                ST_IDLE:
                begin
                    if ((b & LEN_MASK) == 0)
                    begin
                        hdr_phase = ST_LONG_OFF;
                    end
                    else
                    begin
                        short_cnt = short_cnt + 1'b1;
                        hdr_phase = (short_cnt == 0) ? ST_IDLE : ST_SHORT_OFF;
                    end
                end
                ST_SHORT_OFF: hdr_phase = ST_IDLE;
                ST_LONG_OFF:  hdr_phase = ST_LONG_LEN;
                default:      hdr_phase = ST_IDLE;
            endcase
        end
    endtask

    // A packet byte after the header, sometimes preceded by a literal.
    task automatic pkt_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < mid_lit_pct)
            send_item(1'b1, 8'($urandom));
        send_item(1'b0, b);
    endtask

    // Complete any packet left open by noise.
    task automatic close_packet();
        while (hdr_phase != ST_IDLE)
            pkt_byte(8'($urandom));
    endtask

    task automatic send_short(input logic [7:0] hdr, input logic [7:0] off_byte);
        close_packet();
        send_item(1'b0, hdr);
        if (hdr_phase == ST_SHORT_OFF)
            pkt_byte(off_byte);
    endtask

    task automatic send_long(input logic [9:0] off_field, input logic [7:0] len_byte);
        close_packet();
        send_item(1'b0, {off_field[9:8], 6'b0});
        pkt_byte(off_field[7:0]);
        pkt_byte(len_byte);
    endtask

    // Mostly short copies, now and then up to the longest.
    function automatic logic [5:0] pick_short_len();
        return ($urandom_range(0, 99) < 85) ? 6'($urandom_range(1, 10))
                                            : 6'($urandom_range(1, 63));
    endfunction

    function automatic logic [7:0] pick_long_len();
        return ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 12))
                                            : 8'($urandom_range(0, 255));
    endfunction

    // Main stimulus.
    initial
    begin
        int rand_start;
        int pick;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: copy from never-written history, then literals at both extremes.
        send_long(10'd4, 8'd2);
        send_item(1'b1, 8'h00);
        send_item(1'b1, 8'hFF);
        send_item(1'b1, 8'hA5);
        send_item(1'b1, 8'h5A);
        // Short packets: overlapping copy, a literal inside a packet, the longest short copy.
        send_short(8'h41, 8'h00);
        send_item(1'b0, 8'h83);
        send_item(1'b1, 8'h77);
        send_item(1'b0, 8'h03);
        send_short(8'hFF, 8'hFF);
        // Fourth short packet takes its offset from the recycled bits.
        send_short(8'hC1, 8'h00);
        // Long packets: full-depth offset with the longest copy, shortest copy with a literal.
        send_long(10'h3FF, 8'hFF);
        send_item(1'b0, 8'h00);
        send_item(1'b1, 8'h3C);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'h00);
        send_long(10'h200, 8'h00);

        // Random: mostly well-formed packets, literal runs and some raw noise.
        mid_lit_pct = 5;
        rand_start  = requests_sent;
        while (requests_sent < REQUEST_TARGET)
        begin
            if (tx_idle_pct == 18
                && requests_sent >= rand_start + (REQUEST_TARGET - rand_start) / 3)
            begin
                tx_idle_pct = 69;
                rx_idle_pct = 18;
                // Long output hold-off while packets keep coming.
                rx_hold_go = 1'b1;
                send_long(10'($urandom_range(0, 1023)), 8'hFF);
                send_short({2'($urandom), pick_short_len()}, 8'($urandom));
            end
            else if (tx_idle_pct == 69
                     && requests_sent >= rand_start + 2 * (REQUEST_TARGET - rand_start) / 3)
            begin
                // Sender pause until every copy group has come back.
                @(negedge clk);
                s_tvalid <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                send_short({2'($urandom), pick_short_len()}, 8'($urandom));
            end
            else if (pick < 60)
            begin
                send_long(10'($urandom_range(0, 1023)), pick_long_len());
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 6)) send_item(1'b1, 8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 4)) send_item(1'($urandom), 8'($urandom));
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d requests (%0d literals) and checked %0d copy groups,",
                 requests_sent, literals_sent, groups_seen);
        $display("%s", {"with short, recycled and long packets, ",
                        "a full-depth 258-byte copy and a long stall."});
        if (fail_count == 0 && pending == 0)
            $display("tb_lz_backref_packet_decoder passed");
        else
            $display("tb_lz_backref_packet_decoder failed");
        $finish;
    end

endmodule

`default_nettype wire
